// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/u8sd_pkg.sv
// Types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned LenWidth   = 3;
  localparam int unsigned StatWidth  = 2;
  localparam int unsigned TotalWidth = 16;

  localparam logic [StatWidth-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatWidth-1:0] STATUS_SKIP  = 2'd1;
  localparam logic [StatWidth-1:0] STATUS_TRUNC = 2'd2;

  localparam logic [LenWidth-1:0] LEN_SKIP = 3'd0;
  localparam logic [LenWidth-1:0] LEN_ONE  = 3'd1;
  localparam logic [LenWidth-1:0] LEN_TWO  = 3'd2;
  localparam logic [LenWidth-1:0] LEN_THREE = 3'd3;
  localparam logic [LenWidth-1:0] LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [CpWidth-1:0]    code_point;
    logic [LenWidth-1:0]   char_bytes;
    logic [StatWidth-1:0]  status;
    logic [TotalWidth-1:0] char_total;
    logic                  string_end;
  } res_t;

endpackage

// File: rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: byte-serial decode to code points.
// Decode is shifts and masks on the state registers. Each result is registered in the output
// register, or in the skid if it is held. One byte per cycle is taken while the skid is empty.
// A two-entry output (register plus skid) keeps bytes flowing while one result waits.
// Reset (rst_ni low, asynchronous) clears the decode state, the count and both output slots.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_stream_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            is_final_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [u8sd_pkg::CpWidth-1:0]    code_point_o,
  output logic [u8sd_pkg::LenWidth-1:0]   char_bytes_o,
  output logic [u8sd_pkg::StatWidth-1:0]  status_o,
  output logic [u8sd_pkg::TotalWidth-1:0] char_total_o,
  output logic                            string_end_o
);
  import u8sd_pkg::*;

  // Decode state
  logic [1:0]             rem_q, rem_d;    // continuation bytes still expected
  logic [CpWidth-1:0]     part_q, part_d;  // code point bits gathered so far
  logic [LenWidth-1:0]    len_q, len_d;    // length of the character in progress
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;    // completed characters, saturating

  logic                   in_fire;
  logic                   res_valid;
  res_t                   res;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [31:0]            cnt_ext;

  // Output register and skid slot
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_take;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  assign cnt_inc = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);

  // --- decode step ---------------------------------------------------------
  always_comb begin
    rem_d     = rem_q;
    part_d    = part_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    res_valid = 1'b0;
    res       = '0;

    if (rem_q == 2'd0) begin
      priority if (!in_byte_i[7]) begin
        // plain ASCII, zero byte included
        cnt_d          = cnt_inc;
        res_valid      = 1'b1;
        res.code_point = CpWidth'(in_byte_i);
        res.char_bytes = LEN_ONE;
        res.status     = STATUS_OK;
      end else if (in_byte_i[7:4] == 4'hF) begin
        part_d = CpWidth'(in_byte_i[2:0]);
        len_d  = LEN_FOUR;
        rem_d  = 2'd3;
      end else if (in_byte_i[7:5] == 3'b111) begin
        part_d = CpWidth'(in_byte_i[3:0]);
        len_d  = LEN_THREE;
        rem_d  = 2'd2;
      end else if (in_byte_i[7:6] == 2'b11) begin
        part_d = CpWidth'(in_byte_i[4:0]);
        len_d  = LEN_TWO;
        rem_d  = 2'd1;
      end else begin
        // lone continuation byte where a lead byte belongs
        res_valid      = 1'b1;
        res.code_point = '0;
        res.char_bytes = LEN_SKIP;
        res.status     = STATUS_SKIP;
      end
    end else begin
      // continuation: low six bits shifted in, byte not checked
      part_d = {part_q[CpWidth-7:0], in_byte_i[5:0]};
      rem_d  = rem_q - 2'd1;
      if (rem_d == 2'd0) begin
        cnt_d          = cnt_inc;
        res_valid      = 1'b1;
        res.code_point = part_d;
        res.char_bytes = len_q;
        res.status     = STATUS_OK;
        part_d         = '0;
        len_d          = '0;
      end
    end

    cnt_ext        = 32'(cnt_d);
    res.char_total = cnt_ext[TotalWidth-1:0];
    res.string_end = is_final_i;

    if (is_final_i) begin
      if (rem_d != 2'd0) begin
        // string ends inside a character
        res_valid      = 1'b1;
        res.code_point = part_d;
        res.char_bytes = len_d;
        res.status     = STATUS_TRUNC;
      end
      rem_d  = '0;
      part_d = '0;
      len_d  = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      part_q <= '0;
      len_q  <= '0;
      cnt_q  <= '0;
    end else if (in_fire) begin
      rem_q  <= rem_d;
      part_q <= part_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
    end
  end

  // --- output register and skid slot ---------------------------------------
  // A new result goes to the output register when it is free or drains this
  // cycle with the skid empty; otherwise it lands in the skid.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q) begin
      if (in_fire && res_valid) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = in_fire && res_valid;
        skid_d       = res;
      end else begin
        out_valid_d = in_fire && res_valid;
        out_d       = res;
      end
    end else if (in_fire && res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = out_q.code_point;
  assign char_bytes_o = out_q.char_bytes;
  assign status_o     = out_q.status;
  assign char_total_o = out_q.char_total;
  assign string_end_o = out_q.string_end;

  // --- assertions ----------------------------------------------------------
  `ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q, "skid holds a result ahead of the output register")
  `ASSERT_CLK(a_final_clears, (in_fire && is_final_i) |=> (rem_q == 2'd0 && cnt_q == '0 && len_q == '0), "state not cleared after final byte")
  `ASSERT_CLK(a_trunc_at_end, (out_valid_q && out_q.status == STATUS_TRUNC) |-> out_q.string_end, "truncation reported off the final byte")
  `ASSERT_CLK(a_len_covers_rem, (rem_q != 2'd0) |-> ({1'b0, rem_q} < len_q), "pending length shorter than bytes still expected")

endmodule

// File: tb/utf8_stream_decoder_tb.sv
// Self-checking testbench for the UTF-8 stream decoder: random/directed byte streams vs. a local decoder.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

  import u8sd_pkg::*;

  localparam int unsigned CountWidth  = 16;      // matches the DUT default
  localparam int unsigned RandomBytes = 1600;    // size of the random part
  localparam int unsigned HoldCycles  = 400;     // long receiver hold-off
  localparam int unsigned DrainCycles = 16;      // quiet time after the last result
  localparam int unsigned CycleLimit  = 800_000; // hard timeout

  // One byte request: payload plus a flag that turns off idling on both sides.
  typedef struct {
    logic [7:0] data;
    logic       is_last;
    bit         rush;
  } byte_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_byte = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CpWidth-1:0]    code_point;
  logic [LenWidth-1:0]   char_bytes;
  logic [StatWidth-1:0]  status;
  logic [TotalWidth-1:0] char_total;
  logic                  string_end;

  byte_req_t   req_q[$];      // byte requests not yet offered
  logic [7:0]  draft_q[$];    // bytes of the string being built
  res_t        decoded_q[$];  // decoded characters still to come out

  // Local decoder state.
  logic [1:0]            cont_left  = '0;
  logic [CpWidth-1:0]    cp_accum   = '0;
  logic [LenWidth-1:0]   seq_len    = '0;
  logic [CountWidth-1:0] char_count = '0;

  int unsigned accepted_cnt = 0;
  int unsigned req_total    = 0;
  int unsigned squeeze_at   = '1;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  logic        rcv_rush     = 1'b0;
  logic        hold_off     = 1'b0;

  utf8_stream_decoder #(
    .COUNT_WIDTH(CountWidth)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .is_final_i  (in_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .code_point_o(code_point),
    .char_bytes_o(char_bytes),
    .status_o    (status),
    .char_total_o(char_total),
    .string_end_o(string_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction: one accepted byte in, zero or one decoded character out.
  // ---------------------------------------------------------------------------
  function automatic void decode_byte(input logic [7:0] data, input logic is_last);
    res_t res;
    bit   emit;
    emit = 1'b0;
    res  = '0;
    res.string_end = is_last;
    if (cont_left == 2'd0) begin
      if (!data[7]) begin
        // plain ASCII, NUL included
        if (char_count != '1) char_count++;
        res.code_point = CpWidth'(data);
        res.char_bytes = LEN_ONE;
        res.status     = STATUS_OK;
        emit = 1'b1;
      end else if (data[7:4] == 4'b1111) begin
        // 0xF0 and up all count as four-byte leads
        cp_accum  = CpWidth'(data[2:0]);
        seq_len   = LEN_FOUR;
        cont_left = 2'd3;
      end else if (data[7:4] == 4'b1110) begin
        cp_accum  = CpWidth'(data[3:0]);
        seq_len   = LEN_THREE;
        cont_left = 2'd2;
      end else if (data[7:5] == 3'b110) begin
        cp_accum  = CpWidth'(data[4:0]);
        seq_len   = LEN_TWO;
        cont_left = 2'd1;
      end else begin
        // continuation byte where a lead belongs: skipped, count untouched
        res.code_point = '0;
        res.char_bytes = LEN_SKIP;
        res.status     = STATUS_SKIP;
        emit = 1'b1;
      end
    end else begin
      // continuation bytes are taken as-is, low six bits only
      cp_accum  = {cp_accum[CpWidth-7:0], data[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (char_count != '1) char_count++;
        res.code_point = cp_accum;
        res.char_bytes = seq_len;
        res.status     = STATUS_OK;
        emit = 1'b1;
        cp_accum = '0;
        seq_len  = '0;
      end
    end
    res.char_total = char_count[TotalWidth-1:0];
    if (is_last) begin
      if (cont_left != 2'd0) begin
        // string ended inside a character: report what was gathered
        res.code_point = cp_accum;
        res.char_bytes = seq_len;
        res.status     = STATUS_TRUNC;
        res.char_total = char_count[TotalWidth-1:0];
        emit = 1'b1;
      end
      cont_left  = '0;
      cp_accum   = '0;
      seq_len    = '0;
      char_count = '0;
    end
    if (emit) decoded_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void push_req(input logic [7:0] data, input logic is_last,
                                   input bit rush);
    byte_req_t req;
    req.data    = data;
    req.is_last = is_last;
    req.rush    = rush;
    req_q.push_back(req);
  endfunction

  // Lead byte of a len-byte character plus n_cont continuation bytes.
  // Now and then a continuation is a fully random byte (they are unchecked).
  function automatic void add_char(input int unsigned len, input int unsigned n_cont);
    case (len)
      1:       draft_q.push_back(8'($urandom_range(0, 127)));
      2:       draft_q.push_back({3'b110, 5'($urandom)});
      3:       draft_q.push_back({4'b1110, 4'($urandom)});
      default: draft_q.push_back({4'b1111, 4'($urandom)});
    endcase
    for (int i = 0; i < n_cont; i++) begin
      if ($urandom_range(0, 15) == 0) draft_q.push_back(8'($urandom));
      else draft_q.push_back({2'b10, 6'($urandom)});
    end
  endfunction

  // Hand the drafted string to the request queue, flagging its last byte.
  function automatic void seal_string();
    while (draft_q.size() != 0) begin
      push_req(draft_q[0], draft_q.size() == 1, 1'b0);
      void'(draft_q.pop_front());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers requests from req_q, random gap per request, predicts on
  // every accepted byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_req_t   req;
    logic        offer;
    bit          gap_armed;
    bit          send_calm;
    int unsigned send_gap;
    if (rst_n) begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        decode_byte(in_byte, in_last);
        accepted_cnt <= accepted_cnt + 1;
        offer = 1'b0;
        // flip between idling and back-to-back stretches now and then
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
      end
      if (!offer && req_q.size() != 0) begin
        if (!gap_armed) begin
          send_gap  = (req_q[0].rush || send_calm) ? 0 : $urandom_range(0, 12);
          gap_armed = 1'b1;
        end
        if (send_gap == 0) begin
          req = req_q.pop_front();
          in_byte  <= req.data;
          in_last  <= req.is_last;
          rcv_rush <= req.rush;
          offer     = 1'b1;
          gap_armed = 1'b0;
        end else begin
          send_gap--;
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random receiver stalls, compares each result with the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t        want;
    bit          rcv_calm;
    int unsigned rcv_gap;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: code_point %0h status %0d", code_point, status);
          err_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (code_point !== want.code_point) begin
            $error("code_point: expected %0h, got %0h", want.code_point, code_point);
            err_cnt++;
          end
          if (char_bytes !== want.char_bytes) begin
            $error("char_bytes: expected %0d, got %0d", want.char_bytes, char_bytes);
            err_cnt++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            err_cnt++;
          end
          if (char_total !== want.char_total) begin
            $error("char_total: expected %0d, got %0d", want.char_total, char_total);
            err_cnt++;
          end
          if (string_end !== want.string_end) begin
            $error("string_end: expected %0d, got %0d", want.string_end, string_end);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 49) == 0) rcv_calm = !rcv_calm;
        rcv_gap = (rcv_calm || rcv_rush) ? 0 : $urandom_range(0, 12);
      end else if (rcv_gap > 0) begin
        rcv_gap--;
      end
      out_ready <= !hold_off && (rcv_gap == 0);
    end
  end

  // Long receiver hold-off, once, early in the random part: the output slots
  // fill and the input must back up while the driver keeps offering.
  always @(posedge clk) begin
    int unsigned hold_left;
    bit          hold_done;
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && accepted_cnt >= squeeze_at) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    hold_off <= (hold_left > 0);
  end

  // Timeout.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus build, reset, end of test.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned len;

    // Directed: field extremes, every length, skips, truncation, final flags.
    push_req(8'h00, 1'b0, 1'b0);                  // NUL is a character
    push_req(8'h7F, 1'b0, 1'b0);
    push_req(8'hC0, 1'b0, 1'b0);                  // lowest two-byte lead
    push_req(8'h80, 1'b0, 1'b0);
    push_req(8'hDF, 1'b0, 1'b0);
    push_req(8'hBF, 1'b0, 1'b0);
    push_req(8'hEF, 1'b0, 1'b0);                  // continuations not checked
    push_req(8'hFF, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b0);
    push_req(8'hF0, 1'b0, 1'b0);
    push_req(8'h90, 1'b0, 1'b0);
    push_req(8'h80, 1'b0, 1'b0);
    push_req(8'h80, 1'b0, 1'b0);
    push_req(8'hFF, 1'b0, 1'b0);                  // 0xF8 and up act as four-byte leads
    push_req(8'hBF, 1'b0, 1'b0);
    push_req(8'hBF, 1'b0, 1'b0);
    push_req(8'hBF, 1'b0, 1'b0);
    push_req(8'h80, 1'b0, 1'b0);                  // lone continuation bytes
    push_req(8'hBF, 1'b0, 1'b0);
    push_req(8'hF4, 1'b0, 1'b0);                  // string cut inside a character
    push_req(8'h8F, 1'b1, 1'b0);
    push_req(8'h41, 1'b1, 1'b0);                  // final on ASCII
    push_req(8'h80, 1'b1, 1'b0);                  // final on a skipped byte
    push_req(8'hC3, 1'b0, 1'b0);
    push_req(8'hA9, 1'b1, 1'b0);                  // final completes a character

    // Short string with no idling on either side.
    push_req(8'hC3, 1'b0, 1'b1);
    push_req(8'hA9, 1'b0, 1'b1);
    push_req(8'hE2, 1'b1, 1'b1);                  // truncated right after a full char

    squeeze_at = req_q.size() + 300;
    req_total  = req_q.size() + RandomBytes;

    // Random strings: mostly well-formed characters, some noise bytes and
    // some strings cut short inside a character.
    while (req_q.size() < req_total) begin
      for (int n = $urandom_range(1, 16); n > 0; n--) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      add_char(1, 0);
        else if (pick < 50) add_char(2, 1);
        else if (pick < 68) add_char(3, 2);
        else if (pick < 86) add_char(4, 3);
        else                draft_q.push_back(8'($urandom));
      end
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(2, 4);
        add_char(len, $urandom_range(0, len - 2));
      end
      seal_string();
    end
    req_total = req_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Every request taken and every result seen, then a quiet stretch to
    // catch anything extra.
    while (accepted_cnt != req_total || decoded_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: utf8_stream_decoder.f
+incdir+rtl/core
rtl/core/u8sd_pkg.sv
rtl/core/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
